// ----- hw/rtl/ftw_pkg.sv -----
// Shared types and codes for the flow timeout timer wheel.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package ftw_pkg;

   // Command modes
   localparam logic [1:0] MODE_ADD    = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_HIT    = 2'd2;
   localparam logic [1:0] MODE_TICK   = 2'd3;

   // Result kinds
   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_EXPIRE = 2'd1;
   localparam logic [1:0] KIND_DONE   = 2'd2;

   // Expiry reasons
   localparam logic [1:0] REASON_NONE = 2'd0;
   localparam logic [1:0] REASON_IDLE = 2'd1;
   localparam logic [1:0] REASON_HARD = 2'd2;

   typedef struct packed {
      logic [1:0]  mode;
      logic [4:0]  flow_id;
      logic [15:0] idle_ttl;
      logic [15:0] hard_ttl;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [4:0] flow_out;
      logic [1:0] reason;
      logic       status;
      logic       last;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic load;     // capture request, reset scan index
      logic command;  // apply add/remove/hit to the captured flow
      logic scan;     // evaluate and update the flow at the scan index
      logic advance;  // step the wheel position
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_tick;
      logic expire;    // scanned flow expires
      logic scan_last; // scan index is the final flow
   } sts_type;

endpackage

// ----- hw/rtl/flow_timeout_timer_wheel_core.sv -----
// Flow timeout timer wheel: add/remove/hit are applied directly; a tick scans one flow record per cycle,
// holding on an expiry until the output register is free.
// One item is in work at a time; the output register frees the next item.
// Synchronous reset clears the wheel position, armed bits and activity marks.
// Depends on ftw_pkg, ftw_ctrl and ftw_dp.
`timescale 1ns / 1ps

module flow_timeout_timer_wheel_core #(
   parameter int SLOTS = 256,
   parameter int FLOWS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ftw_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ftw_pkg::rsp_type rsp_data
);

   ftw_pkg::cmd_type cmd;
   ftw_pkg::sts_type sts;
   logic rsp_free, emit, emit_done;

   ftw_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_free, .sts, .cmd, .emit, .emit_done
   );

   ftw_dp #(.SLOTS(SLOTS), .FLOWS(FLOWS)) u_dp (
      .clock, .reset, .req_data, .cmd, .emit, .emit_done, .sts, .rsp_free,
      .rsp_valid, .rsp_stall, .rsp_data
   );

   // A result is only loaded when the output register can take it
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit |-> rsp_free) else $error("result overwritten");

   // The tick finished result always closes its item
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      emit_done |=> rsp_valid && rsp_data.last) else $error("tick end not last");

   // Nothing is accepted while a command or scan is in work
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan || cmd.command) |-> req_stall) else $error("accept during work");

endmodule

// ----- hw/rtl/ftw_ctrl.sv -----
// Controller of the flow timeout timer wheel: sequences commands and tick scans.
// Depends on ftw_pkg.
`timescale 1ns / 1ps

module ftw_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             rsp_free,
   input  ftw_pkg::sts_type sts,
   output ftw_pkg::cmd_type cmd,
   output logic             emit,
   output logic             emit_done
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CMD  = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   // Decode the state into datapath commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      emit      = 1'b0;
      emit_done = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CMD;
            end
         end
         ST_CMD: begin
            if (sts.is_tick) begin
               state_in = ST_SCAN;
            end else if (rsp_free) begin
               cmd.command = 1'b1;
               emit        = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_SCAN: begin
            // hold on an expiry until the output register frees up
            if (!sts.expire || rsp_free) begin
               cmd.scan = 1'b1;
               emit     = sts.expire;
               if (sts.scan_last) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               cmd.advance = 1'b1;
               emit        = 1'b1;
               emit_done   = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hw/rtl/ftw_dp.sv -----
// Datapath of the flow timeout timer wheel: flow records, wheel position, output register.
// Depends on ftw_pkg.
`timescale 1ns / 1ps

module ftw_dp #(
   parameter int SLOTS = 256,
   parameter int FLOWS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  ftw_pkg::req_type req_data,
   input  ftw_pkg::cmd_type cmd,
   input  logic             emit,
   input  logic             emit_done,
   output ftw_pkg::sts_type sts,
   output logic             rsp_free,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ftw_pkg::rsp_type rsp_data
);

   localparam int SW = $clog2(SLOTS);
   localparam int FW = $clog2(FLOWS);
   localparam logic [16:0] LIMIT = 17'(SLOTS - 2);

   ftw_pkg::req_type req_ff;
   logic [FW-1:0]    idx_ff;
   logic [SW-1:0]    cur_ff;
   logic [FLOWS-1:0] idle_armed_ff, hard_armed_ff, seen_ff;
   logic [SW-1:0]    idle_slot_ff   [FLOWS];
   logic [SW-1:0]    hard_slot_ff   [FLOWS];
   logic [SW-1:0]    idle_period_ff [FLOWS];
   logic             rsp_valid_ff;
   ftw_pkg::rsp_type rsp_ff;

   logic        fid_ok, to_ok, cmd_ok;
   logic [FW-1:0] fidx;
   logic        hard_due, idle_due;
   logic [1:0]  reason;
   logic [SW:0] sum_idle, sum_hard, sum_resched;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign fid_ok = {1'b0, req_ff.flow_id} < 6'(FLOWS);
   assign fidx   = FW'(req_ff.flow_id);
   assign to_ok  = ({1'b0, req_ff.idle_ttl} <= LIMIT)
                && ({1'b0, req_ff.hard_ttl} <= LIMIT);
   assign cmd_ok = fid_ok && (req_ff.mode != ftw_pkg::MODE_ADD || to_ok);

   // Due slot = (current + T) mod SLOTS, with T < SLOTS-1 once checked
   function automatic logic [SW-1:0] wrap(input logic [SW:0] s);
      return (s >= (SW+1)'(SLOTS)) ? SW'(s - (SW+1)'(SLOTS)) : SW'(s);
   endfunction

   assign sum_idle    = {1'b0, cur_ff} + (SW+1)'(req_ff.idle_ttl);
   assign sum_hard    = {1'b0, cur_ff} + (SW+1)'(req_ff.hard_ttl);
   assign sum_resched = {1'b0, cur_ff} + {1'b0, idle_period_ff[idx_ff]};

   // Evaluate the flow at the scan index
   assign hard_due = hard_armed_ff[idx_ff] && hard_slot_ff[idx_ff] == cur_ff;
   assign idle_due = idle_armed_ff[idx_ff] && idle_slot_ff[idx_ff] == cur_ff;
   always_comb begin
      reason = ftw_pkg::REASON_NONE;
      if (hard_due) begin
         reason = ftw_pkg::REASON_HARD;
      end else if (idle_due && !seen_ff[idx_ff]) begin
         reason = ftw_pkg::REASON_IDLE;
      end
   end

   assign sts.is_tick   = req_ff.mode == ftw_pkg::MODE_TICK;
   assign sts.expire    = reason != ftw_pkg::REASON_NONE;
   assign sts.scan_last = idx_ff == FW'(FLOWS - 1);

   // Capture the request and step the scan index
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
         idx_ff <= '0;
      end else if (cmd.scan && !sts.scan_last) begin
         idx_ff <= idx_ff + FW'(1);
      end
   end

   // Per-flow slot tables (no reset, read only while armed)
   always_ff @(posedge clock) begin
      if (cmd.command && cmd_ok && req_ff.mode == ftw_pkg::MODE_ADD) begin
         if (req_ff.idle_ttl != '0) begin
            idle_period_ff[fidx] <= SW'(req_ff.idle_ttl);
            idle_slot_ff[fidx]   <= wrap(sum_idle);
         end
         if (req_ff.hard_ttl != '0) begin
            hard_slot_ff[fidx] <= wrap(sum_hard);
         end
      end else if (cmd.scan && !hard_due && idle_due && seen_ff[idx_ff]) begin
         idle_slot_ff[idx_ff] <= wrap(sum_resched);
      end
   end

   // Armed bits, activity marks and wheel position
   always_ff @(posedge clock) begin
      if (reset) begin
         idle_armed_ff <= '0;
         hard_armed_ff <= '0;
         seen_ff       <= '0;
         cur_ff        <= '0;
      end else begin
         if (cmd.command && cmd_ok) begin
            unique case (req_ff.mode)
               ftw_pkg::MODE_ADD: begin
                  idle_armed_ff[fidx] <= req_ff.idle_ttl != '0;
                  hard_armed_ff[fidx] <= req_ff.hard_ttl != '0;
                  seen_ff[fidx]       <= 1'b0;
               end
               ftw_pkg::MODE_REMOVE: begin
                  idle_armed_ff[fidx] <= 1'b0;
                  hard_armed_ff[fidx] <= 1'b0;
                  seen_ff[fidx]       <= 1'b0;
               end
               default: seen_ff[fidx] <= 1'b1;
            endcase
         end
         if (cmd.scan) begin
            if (sts.expire) begin
               idle_armed_ff[idx_ff] <= 1'b0;
               hard_armed_ff[idx_ff] <= 1'b0;
               seen_ff[idx_ff]       <= 1'b0;
            end else if (idle_due) begin
               seen_ff[idx_ff] <= 1'b0;
            end
         end
         if (cmd.advance) begin
            cur_ff <= (cur_ff == SW'(SLOTS - 1)) ? '0 : cur_ff + SW'(1);
         end
      end
   end

   // Output register: load on emit, drop after transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         if (emit_done) begin
            rsp_ff <= '{ftw_pkg::KIND_DONE, 5'd0, ftw_pkg::REASON_NONE, 1'b0, 1'b1};
         end else if (cmd.scan) begin
            rsp_ff <= '{ftw_pkg::KIND_EXPIRE, 5'(idx_ff), reason, 1'b0, 1'b0};
         end else begin
            rsp_ff <= '{ftw_pkg::KIND_STATUS, req_ff.flow_id, ftw_pkg::REASON_NONE,
                        !cmd_ok, 1'b1};
         end
      end
   end

endmodule
